[hw/rtl/ptm_pkg.sv]
// Shared types and constants for the packed triangular matrix-vector block.
// No dependencies; every other file except ptm_ram refers to this package by scoped names.
package ptm_pkg;

  localparam int MAX_ORDER    = 64;
  localparam int FRAC_BITS    = 16;
  localparam int PACKED_DEPTH = (MAX_ORDER * (MAX_ORDER + 1)) / 2;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = $clog2(MAX_ORDER);
  localparam int ORDER_W = $clog2(MAX_ORDER + 1);
  localparam int POS_W   = $clog2(PACKED_DEPTH);
  localparam int FUNC_W  = 2;
  localparam int PROD_W  = 2 * DATA_W;
  // product width plus headroom for a full row of terms
  localparam int ACC_W   = PROD_W + IDX_W + 2;

  localparam logic [ACC_W-1:0]         ROUND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));
  localparam logic signed [DATA_W-1:0] UNIT_ONE   = DATA_W'(2 ** FRAC_BITS);
  localparam logic [DATA_W-1:0]        SAT_POS    = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic [DATA_W-1:0]        SAT_NEG    = {1'b1, {(DATA_W - 1){1'b0}}};

  // command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // result queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ORDER_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = 3'd4;

  // input func codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD_MAT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD_VEC = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START    = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_MAT,
    OP_LOAD_VEC,
    OP_START
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  index;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic               lower;
    logic               transpose;
    logic               unit;
    logic [ORDER_W-1:0] order_n;
    logic               reverse;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic             unit;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] row;
  } mac_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic              sat;
    logic              last;
  } result_t;

  typedef struct packed {
    logic                 idle;
    logic [OUT_CNT_W-1:0] pending;
  } back_status_t;

  // Column-packed position of A(r,c); lower form uses c*n - c*(c+1)/2 + r.
  function automatic logic [POS_W-1:0] packed_pos(input logic lower,
                                                  input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c,
                                                  input logic [ORDER_W-1:0] n);
    logic [POS_W:0] c_w;
    logic [POS_W:0] tri2;
    logic [POS_W:0] cn;
    logic [POS_W:0] p;
    c_w  = (POS_W + 1)'(c);
    tri2 = (c_w * (c_w + 1'b1)) >> 1;
    cn   = c_w * (POS_W + 1)'(n);
    if (lower) begin
      p = cn - tri2 + (POS_W + 1)'(r);
    end else begin
      p = tri2 + (POS_W + 1)'(r);
    end
    return p[POS_W-1:0];
  endfunction

endpackage

[hw/rtl/ptm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the matrix, vector and result scratch stores.
module ptm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ptm_front.sv]
// Front end: takes input beats, drops ones that do nothing, queues commands.
// Depends on ptm_pkg.
module ptm_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [ptm_pkg::FUNC_W-1:0] func,
  input  logic [ptm_pkg::POS_W-1:0]  element_index,
  input  logic [ptm_pkg::DATA_W-1:0] element_value,
  output logic                       cmd_valid,
  output ptm_pkg::cmd_t              cmd,
  input  logic                       cmd_pop
);

  ptm_pkg::cmd_t                   q [ptm_pkg::CMD_DEPTH];
  logic [ptm_pkg::CMD_PTR_W-1:0]   wr_ptr;
  logic [ptm_pkg::CMD_PTR_W-1:0]   rd_ptr;
  logic [ptm_pkg::CMD_CNT_W-1:0]   count;
  logic                            accept;
  logic                            keep;
  logic                            enq;
  logic                            deq;
  ptm_pkg::op_t                    op;

  assign full      = (count == ptm_pkg::CMD_CNT_W'(ptm_pkg::CMD_DEPTH));
  assign accept    = push && !full;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    keep = 1'b0;
    op   = ptm_pkg::OP_START;
    unique case (func)
      ptm_pkg::FUNC_LOAD_MAT: begin
        op   = ptm_pkg::OP_LOAD_MAT;
        keep = element_index < ptm_pkg::POS_W'(ptm_pkg::PACKED_DEPTH);
      end
      ptm_pkg::FUNC_LOAD_VEC: begin
        op   = ptm_pkg::OP_LOAD_VEC;
        keep = element_index < ptm_pkg::POS_W'(ptm_pkg::MAX_ORDER);
      end
      ptm_pkg::FUNC_START: begin
        op   = ptm_pkg::OP_START;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign enq = accept && keep;
  assign deq = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= '{op: op, index: element_index, value: element_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ptm_pkg::CMD_CNT_W'(enq) - ptm_pkg::CMD_CNT_W'(deq);
    end
  end

endmodule

[hw/rtl/ptm_result_queue.sv]
// Result queue: small register FIFO of finished result beats.
// Depends on ptm_pkg.
module ptm_result_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  ptm_pkg::result_t              wr_data,
  input  logic                          rd_en,
  output ptm_pkg::result_t              rd_data,
  output logic                          empty,
  output logic [ptm_pkg::OUT_CNT_W-1:0] count
);

  ptm_pkg::result_t               q [ptm_pkg::OUT_DEPTH];
  logic [ptm_pkg::OUT_PTR_W-1:0]  wr_ptr;
  logic [ptm_pkg::OUT_PTR_W-1:0]  rd_ptr;
  logic                           deq;

  assign empty   = (count == '0);
  assign rd_data = q[rd_ptr];
  assign deq     = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ptm_pkg::OUT_CNT_W'(wr_en) - ptm_pkg::OUT_CNT_W'(deq);
    end
  end

endmodule

[hw/rtl/ptm_back.sv]
// Back end: executes loads, walks the triangle through a MAC pipeline,
// rounds each row and copies results back. Depends on ptm_pkg and ptm_ram.
module ptm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ptm_pkg::cfg_t                 cfg,
  input  logic                          cmd_valid,
  input  ptm_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic [ptm_pkg::OUT_CNT_W-1:0] out_count,
  output logic                          res_push,
  output ptm_pkg::result_t              res,
  output ptm_pkg::back_status_t         status
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAC   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_COPY  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [ptm_pkg::ORDER_W-1:0]   n_eff;
  logic [ptm_pkg::IDX_W-1:0]     n_m1;
  logic                          tri_lo;

  logic [ptm_pkg::IDX_W-1:0]     row_i;
  logic [ptm_pkg::IDX_W-1:0]     row_i_next;
  logic [ptm_pkg::IDX_W-1:0]     col_j;
  logic [ptm_pkg::IDX_W-1:0]     col_j_next;
  logic [ptm_pkg::IDX_W-1:0]     copy_idx;
  logic [ptm_pkg::IDX_W-1:0]     copy_idx_next;
  logic [ptm_pkg::OUT_CNT_W-1:0] pending;

  logic [ptm_pkg::IDX_W-1:0]     row_start;
  logic [ptm_pkg::IDX_W-1:0]     row_end;
  logic                          row_first;
  logic                          row_last;
  logic                          credit_ok;
  logic                          issue;
  logic [ptm_pkg::IDX_W-1:0]     r_sel;
  logic [ptm_pkg::IDX_W-1:0]     c_sel;
  logic [ptm_pkg::POS_W-1:0]     mat_raddr;
  logic [ptm_pkg::IDX_W-1:0]     vec_raddr;

  logic                          copy_wr;
  logic [ptm_pkg::IDX_W-1:0]     copy_waddr;

  logic                          mat_we;
  logic                          vec_we;
  logic [ptm_pkg::IDX_W-1:0]     vec_waddr;
  logic [ptm_pkg::DATA_W-1:0]    vec_wdata;
  logic signed [ptm_pkg::DATA_W-1:0] mat_rdata;
  logic signed [ptm_pkg::DATA_W-1:0] vec_rdata;
  logic [ptm_pkg::DATA_W-1:0]    scr_rdata;
  logic [ptm_pkg::IDX_W-1:0]     scr_waddr;

  ptm_pkg::mac_ctl_t             p1;
  ptm_pkg::mac_ctl_t             p2;
  logic signed [ptm_pkg::DATA_W-1:0] a_op;
  logic signed [ptm_pkg::PROD_W-1:0] prod;
  logic signed [ptm_pkg::ACC_W-1:0]  acc;
  logic signed [ptm_pkg::ACC_W-1:0]  acc_next;
  logic                          p3_valid;
  logic [ptm_pkg::IDX_W-1:0]     p3_row;

  logic signed [ptm_pkg::ACC_W-1:0]  rnd;
  logic signed [ptm_pkg::ACC_W-1:0]  shifted;
  logic [ptm_pkg::ACC_W-ptm_pkg::DATA_W:0] upper_bits;
  logic                          fits;

  assign n_eff  = (cfg.order_n > ptm_pkg::ORDER_W'(ptm_pkg::MAX_ORDER))
                  ? ptm_pkg::ORDER_W'(ptm_pkg::MAX_ORDER) : cfg.order_n;
  assign n_m1   = ptm_pkg::IDX_W'(n_eff - 1'b1);
  // row i spans columns 0..i or i..n-1 depending on triangle and transpose
  assign tri_lo = cfg.lower ^ cfg.transpose;

  assign row_start = tri_lo ? '0 : row_i;
  assign row_end   = tri_lo ? row_i : n_m1;
  assign row_first = (col_j == row_start);
  assign row_last  = (col_j == row_end);
  // a row starts only when the result queue has a slot reserved for it
  assign credit_ok = ((ptm_pkg::OUT_CNT_W + 1)'(out_count)
                      + (ptm_pkg::OUT_CNT_W + 1)'(pending))
                     < (ptm_pkg::OUT_CNT_W + 1)'(ptm_pkg::OUT_DEPTH);
  assign issue     = (state == ST_MAC) && (!row_first || credit_ok);

  assign r_sel     = cfg.transpose ? col_j : row_i;
  assign c_sel     = cfg.transpose ? row_i : col_j;
  assign mat_raddr = ptm_pkg::packed_pos(cfg.lower, r_sel, c_sel, n_eff);
  assign vec_raddr = cfg.reverse ? (n_m1 - col_j) : col_j;

  assign cmd_pop = (state == ST_IDLE) && cmd_valid && !copy_wr;

  always_comb begin
    state_next    = state;
    row_i_next    = row_i;
    col_j_next    = col_j;
    copy_idx_next = copy_idx;
    unique case (state)
      ST_IDLE: begin
        if (cmd_pop && (cmd.op == ptm_pkg::OP_START) && (n_eff != '0)) begin
          state_next = ST_MAC;
          row_i_next = '0;
          col_j_next = '0;
        end
      end
      ST_MAC: begin
        if (issue) begin
          if (row_last) begin
            if (row_i == n_m1) begin
              state_next = ST_DRAIN;
            end else begin
              row_i_next = row_i + 1'b1;
              col_j_next = tri_lo ? '0 : (row_i + 1'b1);
            end
          end else begin
            col_j_next = col_j + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (pending == '0) begin
          state_next    = ST_COPY;
          copy_idx_next = '0;
        end
      end
      ST_COPY: begin
        if (copy_idx == n_m1) begin
          state_next = ST_IDLE;
        end else begin
          copy_idx_next = copy_idx + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pending  <= '0;
      copy_wr  <= 1'b0;
      p1.valid <= 1'b0;
      p2.valid <= 1'b0;
      p3_valid <= 1'b0;
      res_push <= 1'b0;
    end else begin
      state    <= state_next;
      pending  <= pending + ptm_pkg::OUT_CNT_W'(issue && row_first)
                  - ptm_pkg::OUT_CNT_W'(res_push);
      copy_wr  <= (state == ST_COPY);
      p1.valid <= issue;
      p2.valid <= p1.valid;
      p3_valid <= p2.valid && p2.last;
      res_push <= p3_valid;
    end
  end

  // walk counters and pipeline payload
  always_ff @(posedge clk) begin
    row_i      <= row_i_next;
    col_j      <= col_j_next;
    copy_idx   <= copy_idx_next;
    copy_waddr <= copy_idx;
    p1.unit    <= cfg.unit && (col_j == row_i);
    p1.first   <= row_first;
    p1.last    <= row_last;
    p1.row     <= row_i;
    p2.unit    <= p1.unit;
    p2.first   <= p1.first;
    p2.last    <= p1.last;
    p2.row     <= p1.row;
    prod       <= a_op * vec_rdata;
    p3_row     <= p2.row;
    if (p2.valid) begin
      acc <= acc_next;
    end
  end

  assign a_op     = p1.unit ? ptm_pkg::UNIT_ONE : mat_rdata;
  assign acc_next = (p2.first ? '0 : acc) + ptm_pkg::ACC_W'(prod);

  // round half up, then clip to 32 bits
  assign rnd        = acc + ptm_pkg::ROUND_HALF;
  assign shifted    = rnd >>> ptm_pkg::FRAC_BITS;
  assign upper_bits = shifted[ptm_pkg::ACC_W-1:ptm_pkg::DATA_W-1];
  assign fits       = (&upper_bits) || !(|upper_bits);

  always_ff @(posedge clk) begin
    res.idx   <= p3_row;
    res.sat   <= !fits;
    res.last  <= (p3_row == n_m1);
    if (fits) begin
      res.value <= shifted[ptm_pkg::DATA_W-1:0];
    end else begin
      res.value <= shifted[ptm_pkg::ACC_W-1] ? ptm_pkg::SAT_NEG : ptm_pkg::SAT_POS;
    end
  end

  assign scr_waddr = cfg.reverse ? (n_m1 - res.idx) : res.idx;

  assign mat_we    = cmd_pop && (cmd.op == ptm_pkg::OP_LOAD_MAT);
  assign vec_we    = copy_wr || (cmd_pop && (cmd.op == ptm_pkg::OP_LOAD_VEC));
  assign vec_waddr = copy_wr ? copy_waddr : cmd.index[ptm_pkg::IDX_W-1:0];
  assign vec_wdata = copy_wr ? scr_rdata : cmd.value;

  ptm_ram #(.WIDTH(ptm_pkg::DATA_W), .DEPTH(ptm_pkg::PACKED_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (cmd.index),
    .wdata (cmd.value),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  ptm_ram #(.WIDTH(ptm_pkg::DATA_W), .DEPTH(ptm_pkg::MAX_ORDER)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (vec_wdata),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  // results land here first so every row still sees the original vector
  ptm_ram #(.WIDTH(ptm_pkg::DATA_W), .DEPTH(ptm_pkg::MAX_ORDER)) u_scr_ram (
    .clk   (clk),
    .we    (res_push),
    .waddr (scr_waddr),
    .wdata (res.value),
    .raddr (copy_idx),
    .rdata (scr_rdata)
  );

  assign status.idle    = (state == ST_IDLE);
  assign status.pending = pending;

endmodule

[hw/rtl/packed_triangular_matvec_top.sv]
// Loads: one beat per cycle while the command queue is not full; each is written to its store
// when the back end pops it, which it does only while idle. Start: one multiply-accumulate per
// cycle over n(n+1)/2 terms, held only at a row start while the result queue has no free slot;
// a row's result passes the p1, p2, p3 and res registers into the result queue. After the last
// row the back end drains, then copies the results into the vector store.
// Reset (rst, synchronous): control registers reset, queues empty; stores stay undefined.
// Top level: configuration registers, front end, back end and result queue.
module packed_triangular_matvec_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [ptm_pkg::FUNC_W-1:0]     func,
  input  logic [ptm_pkg::POS_W-1:0]      element_index,
  input  logic signed [ptm_pkg::DATA_W-1:0] element_value,
  output logic                           empty,
  input  logic                           pop,
  output logic [ptm_pkg::IDX_W-1:0]      result_index,
  output logic signed [ptm_pkg::DATA_W-1:0] result_value,
  output logic                           saturated,
  output logic                           last_result,
  input  logic                           cfg_we,
  input  logic [ptm_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ptm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ptm_pkg::cfg_t                 cfg;
  logic                          cmd_valid;
  ptm_pkg::cmd_t                 cmd;
  logic                          cmd_pop;
  logic [ptm_pkg::OUT_CNT_W-1:0] out_count;
  logic                          res_push;
  ptm_pkg::result_t              res;
  ptm_pkg::result_t              head;
  ptm_pkg::back_status_t         status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{lower: 1'b0, transpose: 1'b0, unit: 1'b0,
               order_n: ptm_pkg::ORDER_W'(1), reverse: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ptm_pkg::CFG_LOWER:     cfg.lower     <= cfg_wdata[0];
        ptm_pkg::CFG_TRANSPOSE: cfg.transpose <= cfg_wdata[0];
        ptm_pkg::CFG_UNIT:      cfg.unit      <= cfg_wdata[0];
        ptm_pkg::CFG_ORDER:     cfg.order_n   <= cfg_wdata;
        ptm_pkg::CFG_REVERSE:   cfg.reverse   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ptm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .func          (func),
    .element_index (element_index),
    .element_value (element_value),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  ptm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res       (res),
    .status    (status)
  );

  ptm_result_queue u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (head),
    .empty   (empty),
    .count   (out_count)
  );

  assign result_index = head.idx;
  assign result_value = head.value;
  assign saturated    = head.sat;
  assign last_result  = head.last;

  // credit scheme must keep the result queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (out_count < ptm_pkg::OUT_CNT_W'(ptm_pkg::OUT_DEPTH)))
    else $error("result beat pushed into a full queue");

  // results only come out of an active compute
  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !status.idle)
    else $error("result beat while back end idle");

  // back end returns to idle only after every row has landed
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    status.idle |-> (status.pending == '0))
    else $error("idle with rows still in flight");

  // a result beat trails an issuing compute by the pipeline depth
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(res_push) |-> $past(!status.idle, 4))
    else $error("result without a start several cycles earlier");

endmodule

[tb/sv/tb.sv]
// Self-checking bench for packed_triangular_matvec_top: loads, starts, config phases.
// Depends on ptm_pkg and the top module; expected rows come from a local model.
module tb;

  localparam logic [ptm_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int               IDX_MAX       = (1 << ptm_pkg::POS_W) - 1;
  localparam int               ORDER_BIG     = 10;
  localparam int               SETTLE_CYCLES = 150;
  localparam int               STALL_LIMIT   = 20000;
  localparam int               HOLD_CYCLES   = 400;
  localparam logic signed [127:0] ROUND_TERM = 128'sd1 <<< (ptm_pkg::FRAC_BITS - 1);
  localparam logic [ptm_pkg::DATA_W-1:0] HALF_LSB = 32'h0000_8000;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              push = 1'b0;
  logic                              full;
  logic [ptm_pkg::FUNC_W-1:0]        func = '0;
  logic [ptm_pkg::POS_W-1:0]         element_index = '0;
  logic signed [ptm_pkg::DATA_W-1:0] element_value = '0;
  logic                              empty;
  logic                              pop = 1'b0;
  logic [ptm_pkg::IDX_W-1:0]         result_index;
  logic signed [ptm_pkg::DATA_W-1:0] result_value;
  logic                              saturated;
  logic                              last_result;
  logic                              cfg_we = 1'b0;
  logic [ptm_pkg::CFG_IDX_W-1:0]     cfg_addr = '0;
  logic [ptm_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;

  packed_triangular_matvec_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .func          (func),
    .element_index (element_index),
    .element_value (element_value),
    .empty         (empty),
    .pop           (pop),
    .result_index  (result_index),
    .result_value  (result_value),
    .saturated     (saturated),
    .last_result   (last_result),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local copy of the block state
  logic signed [ptm_pkg::DATA_W-1:0] mat_copy [ptm_pkg::PACKED_DEPTH];
  bit                                mat_set  [ptm_pkg::PACKED_DEPTH];
  logic signed [ptm_pkg::DATA_W-1:0] vec_copy [ptm_pkg::MAX_ORDER];
  bit                                vec_set  [ptm_pkg::MAX_ORDER];
  bit                                lower_q, trans_q, unit_q, rev_q;
  logic [ptm_pkg::ORDER_W-1:0]       order_q = 7'd1;

  ptm_pkg::result_t expected_elems[$];
  ptm_pkg::result_t want;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      rx_hold = 0;
  int      mismatch_count = 0;
  int      useful_items = 0;
  int      results_seen = 0;

  task automatic flag_error(input string what);
    if (mismatch_count < 100) $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int active_order();
    return (order_q > ptm_pkg::MAX_ORDER) ? ptm_pkg::MAX_ORDER : int'(order_q);
  endfunction

  function automatic int tri_pos(input int r, input int c, input int n);
    if (!lower_q) return c * (c + 1) / 2 + r;
    return c * n - c * (c - 1) / 2 + (r - c);
  endfunction

  function automatic bit in_triangle(input int r, input int c);
    return lower_q ? (r >= c) : (r <= c);
  endfunction

  // ~55% small values (about +-4.0), the rest full-range or corner values
  function automatic logic [ptm_pkg::DATA_W-1:0] rand_q();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
    if (pick < 75) return $urandom;
    case ($urandom_range(6))
      0: return ptm_pkg::SAT_POS;
      1: return ptm_pkg::SAT_NEG;
      2: return '0;
      3: return '1;
      4: return ptm_pkg::UNIT_ONE;
      5: return -ptm_pkg::UNIT_ONE;
      default: return HALF_LSB;
    endcase
  endfunction

  function automatic logic [ptm_pkg::DATA_W-1:0] small_q();
    return 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
  endfunction

  function automatic logic [ptm_pkg::ORDER_W-1:0] rand_order();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 28) return ptm_pkg::ORDER_W'($urandom_range(9, ORDER_BIG));
    return ptm_pkg::ORDER_W'($urandom_range(1, 8));
  endfunction

  // one start: every row of A*x or A**T*x, rounded, clipped, written back
  task automatic compute_matvec();
    int                                n, i, j, r, c;
    logic signed [ptm_pkg::DATA_W-1:0] xs [ptm_pkg::MAX_ORDER];
    logic signed [127:0]               acc, rnd;
    longint                            term;
    ptm_pkg::result_t                  elem;
    n = active_order();
    if (n == 0) return;
    for (j = 0; j < n; j++) xs[j] = vec_copy[rev_q ? n - 1 - j : j];
    for (i = 0; i < n; i++) begin
      acc = '0;
      for (j = 0; j < n; j++) begin
        r = trans_q ? j : i;
        c = trans_q ? i : j;
        if (in_triangle(r, c)) begin
          if (r == c && unit_q) begin
            term = longint'(xs[j]) * (longint'(1) <<< ptm_pkg::FRAC_BITS);
          end else begin
            term = longint'(mat_copy[tri_pos(r, c, n)]) * longint'(xs[j]);
          end
          acc = acc + term;
        end
      end
      rnd = (acc + ROUND_TERM) >>> ptm_pkg::FRAC_BITS;
      elem.idx  = ptm_pkg::IDX_W'(i);
      elem.last = (i == n - 1);
      if (&rnd[127:31] || ~|rnd[127:31]) begin
        elem.value = rnd[31:0];
        elem.sat   = 1'b0;
      end else begin
        elem.value = rnd[127] ? ptm_pkg::SAT_NEG : ptm_pkg::SAT_POS;
        elem.sat   = 1'b1;
      end
      expected_elems.push_back(elem);
    end
    // write-back after all rows, since every row reads the old vector
    for (i = 0; i < expected_elems.size(); i++) begin
      if (i >= expected_elems.size() - n) begin
        elem = expected_elems[i];
        vec_copy[rev_q ? n - 1 - int'(elem.idx) : int'(elem.idx)] = elem.value;
        vec_set[rev_q ? n - 1 - int'(elem.idx) : int'(elem.idx)]  = 1'b1;
      end
    end
  endtask

  task automatic apply_item(input logic [ptm_pkg::FUNC_W-1:0] f,
                            input logic [ptm_pkg::POS_W-1:0] idx,
                            input logic [ptm_pkg::DATA_W-1:0] val);
    case (f)
      ptm_pkg::FUNC_LOAD_MAT: begin
        if (idx < ptm_pkg::PACKED_DEPTH) begin
          mat_copy[idx] = val;
          mat_set[idx]  = 1'b1;
          useful_items++;
        end
      end
      ptm_pkg::FUNC_LOAD_VEC: begin
        if (idx < ptm_pkg::MAX_ORDER) begin
          vec_copy[idx] = val;
          vec_set[idx]  = 1'b1;
          useful_items++;
        end
      end
      ptm_pkg::FUNC_START: begin
        useful_items++;
        compute_matvec();
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(input logic [ptm_pkg::FUNC_W-1:0] f,
                          input logic [ptm_pkg::POS_W-1:0] idx,
                          input logic [ptm_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    func          <= f;
    element_index <= idx;
    element_value <= val;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    apply_item(f, idx, val);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
    // write-back copy and trailing loads may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic store_reg(input logic [ptm_pkg::CFG_IDX_W-1:0] addr,
                           input logic [ptm_pkg::CFG_DATA_W-1:0] data);
    case (addr)
      ptm_pkg::CFG_LOWER:     lower_q = data[0];
      ptm_pkg::CFG_TRANSPOSE: trans_q = data[0];
      ptm_pkg::CFG_UNIT:      unit_q  = data[0];
      ptm_pkg::CFG_ORDER:     order_q = data;
      ptm_pkg::CFG_REVERSE:   rev_q   = data[0];
      default: ;
    endcase
  endtask

  // back-to-back writes; one-bit registers get junk in their upper bits
  task automatic program_regs(input bit lower, input bit trans, input bit unit,
                              input logic [ptm_pkg::ORDER_W-1:0] order, input bit rev);
    logic [ptm_pkg::CFG_IDX_W-1:0]  addr [6];
    logic [ptm_pkg::CFG_DATA_W-1:0] data [6];
    int                             k;
    addr[0] = ptm_pkg::CFG_REVERSE + ptm_pkg::CFG_IDX_W'($urandom_range(1, 3));
    data[0] = ptm_pkg::CFG_DATA_W'($urandom);
    addr[1] = ptm_pkg::CFG_LOWER;     data[1] = {6'($urandom), lower};
    addr[2] = ptm_pkg::CFG_TRANSPOSE; data[2] = {6'($urandom), trans};
    addr[3] = ptm_pkg::CFG_UNIT;      data[3] = {6'($urandom), unit};
    addr[4] = ptm_pkg::CFG_ORDER;     data[4] = order;
    addr[5] = ptm_pkg::CFG_REVERSE;   data[5] = {6'($urandom), rev};
    for (k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= addr[k];
      cfg_wdata <= data[k];
      @(posedge clk);
      store_reg(addr[k], data[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // load every entry the next start will read that has never been written
  task automatic fill_unwritten();
    int n, r, c, p;
    n = active_order();
    for (c = 0; c < n; c++) begin
      for (r = 0; r < n; r++) begin
        if (in_triangle(r, c) && !(r == c && unit_q)) begin
          p = tri_pos(r, c, n);
          if (!mat_set[p]) send_cmd(ptm_pkg::FUNC_LOAD_MAT, ptm_pkg::POS_W'(p), small_q());
        end
      end
    end
    for (c = 0; c < n; c++) begin
      if (!vec_set[c]) send_cmd(ptm_pkg::FUNC_LOAD_VEC, ptm_pkg::POS_W'(c), small_q());
    end
  endtask

  task automatic random_load();
    int n;
    n = active_order();
    if ($urandom_range(1)) begin
      send_cmd(ptm_pkg::FUNC_LOAD_MAT,
               ptm_pkg::POS_W'(n == 0 ? $urandom_range(0, ptm_pkg::PACKED_DEPTH - 1)
                                      : $urandom_range(0, n * (n + 1) / 2 - 1)), rand_q());
    end else begin
      send_cmd(ptm_pkg::FUNC_LOAD_VEC,
               ptm_pkg::POS_W'($urandom_range(0, (n == 0 ? ptm_pkg::MAX_ORDER : n) - 1)),
               rand_q());
    end
  endtask

  task automatic start_product();
    fill_unwritten();
    send_cmd(ptm_pkg::FUNC_START, ptm_pkg::POS_W'($urandom), $urandom);
  endtask

  // all four triangle/transpose forms, unit diagonal and reversed vector mixed in
  task automatic test_triangle_modes();
    int k;
    for (k = 0; k < 4; k++) begin
      wait_idle();
      program_regs(k[0], k[1], k[1], 7'd3, k[0]);
      random_load();
      random_load();
      start_product();
    end
  endtask

  // n = 1: half-LSB rounding both signs and clipping at both rails
  task automatic test_rounding_saturation();
    logic [ptm_pkg::DATA_W-1:0] a_vals [7];
    logic [ptm_pkg::DATA_W-1:0] x_vals [7];
    int                         k;
    a_vals = '{32'd1, -32'sd1, -32'sd3, ptm_pkg::SAT_POS, ptm_pkg::SAT_NEG,
               ptm_pkg::SAT_NEG, ptm_pkg::UNIT_ONE};
    x_vals = '{HALF_LSB, HALF_LSB, HALF_LSB, ptm_pkg::SAT_POS, ptm_pkg::SAT_POS,
               ptm_pkg::SAT_NEG, '1};
    wait_idle();
    program_regs(1'b0, 1'b0, 1'b0, 7'd1, 1'b0);
    for (k = 0; k < 7; k++) begin
      send_cmd(ptm_pkg::FUNC_LOAD_MAT, '0, a_vals[k]);
      send_cmd(ptm_pkg::FUNC_LOAD_VEC, '0, x_vals[k]);
      send_cmd(ptm_pkg::FUNC_START, '0, '0);
    end
    // far ends of the stores, written but not read at this order
    send_cmd(ptm_pkg::FUNC_LOAD_MAT, ptm_pkg::POS_W'(ptm_pkg::PACKED_DEPTH - 1),
             ptm_pkg::SAT_POS);
    send_cmd(ptm_pkg::FUNC_LOAD_VEC, ptm_pkg::POS_W'(ptm_pkg::MAX_ORDER - 1),
             ptm_pkg::SAT_NEG);
  endtask

  // unused func code and out-of-range loads must leave the stores alone
  task automatic test_ignored_items();
    send_cmd(FUNC_UNUSED, ptm_pkg::POS_W'(IDX_MAX), '1);
    send_cmd(FUNC_UNUSED, '0, '0);
    send_cmd(ptm_pkg::FUNC_LOAD_MAT, ptm_pkg::POS_W'(ptm_pkg::PACKED_DEPTH), $urandom);
    send_cmd(ptm_pkg::FUNC_LOAD_MAT, ptm_pkg::POS_W'(IDX_MAX), $urandom);
    send_cmd(ptm_pkg::FUNC_LOAD_VEC, ptm_pkg::POS_W'(ptm_pkg::MAX_ORDER), $urandom);
    send_cmd(ptm_pkg::FUNC_LOAD_VEC, ptm_pkg::POS_W'(IDX_MAX), $urandom);
    start_product();
  endtask

  // repeated starts multiply the written-back vector again
  task automatic test_writeback();
    wait_idle();
    program_regs(1'b0, 1'b1, 1'b0, 7'd5, 1'b1);
    start_product();
    send_cmd(ptm_pkg::FUNC_START, '0, '0);
    send_cmd(ptm_pkg::FUNC_START, ptm_pkg::POS_W'(IDX_MAX), '1);
  endtask

  task automatic test_order_limits();
    wait_idle();
    program_regs(1'b0, 1'b0, 1'b0, 7'd0, 1'b0);
    send_cmd(ptm_pkg::FUNC_START, '0, '0);
    wait_idle();
    program_regs(1'b1, 1'b1, 1'b0, ptm_pkg::ORDER_W'(ORDER_BIG), 1'b1);
    start_product();
    wait_idle();
    program_regs(1'b0, 1'b0, 1'b1, ptm_pkg::ORDER_W'(ORDER_BIG), 1'b0);
    start_product();
  endtask

  // receiver holds off while starts pile up behind a full result queue
  task automatic test_backpressure();
    int k;
    wait_idle();
    program_regs(1'b0, 1'b0, 1'b0, 7'd4, 1'b0);
    fill_unwritten();
    rx_hold = HOLD_CYCLES;
    for (k = 0; k < 6; k++) begin
      send_cmd(ptm_pkg::FUNC_LOAD_VEC, ptm_pkg::POS_W'($urandom_range(0, 3)), small_q());
      send_cmd(ptm_pkg::FUNC_START, '0, '0);
    end
  endtask

  task automatic test_random(input int target);
    int base_items, base_rows, loads, k;
    base_items = useful_items;
    base_rows  = results_seen;
    while (useful_items - base_items < target || results_seen - base_rows < 24) begin
      k = $urandom_range(99);
      if (k < 10) begin
        wait_idle();
        program_regs(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     rand_order(), 1'($urandom_range(1)));
      end else if (k < 22) begin
        case ($urandom_range(3))
          0: send_cmd(FUNC_UNUSED, ptm_pkg::POS_W'($urandom), $urandom);
          1: send_cmd(ptm_pkg::FUNC_LOAD_MAT,
                      ptm_pkg::POS_W'($urandom_range(ptm_pkg::PACKED_DEPTH, IDX_MAX)),
                      $urandom);
          2: send_cmd(ptm_pkg::FUNC_LOAD_VEC,
                      ptm_pkg::POS_W'($urandom_range(ptm_pkg::MAX_ORDER, IDX_MAX)), $urandom);
          default: start_product();
        endcase
      end else begin
        loads = $urandom_range(0, 5);
        for (k = 0; k < loads; k++) random_load();
        start_product();
      end
    end
  endtask

  // result side: check each beat, then decide pop for the next edge
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_elems.size() == 0) begin
        flag_error($sformatf("result beat index %0d with nothing expected", result_index));
      end else begin
        want = expected_elems.pop_front();
        if (result_index !== want.idx)
          flag_error($sformatf("result_index %0d, expected %0d", result_index, want.idx));
        if (result_value !== want.value)
          flag_error($sformatf("row %0d result_value %h, expected %h", want.idx,
                               result_value, want.value));
        if (saturated !== want.sat)
          flag_error($sformatf("row %0d saturated %b, expected %b", want.idx, saturated,
                               want.sat));
        if (last_result !== want.last)
          flag_error($sformatf("row %0d last_result %b, expected %b", want.idx,
                               last_result, want.last));
      end
      results_seen++;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 62;
    test_triangle_modes();
    test_rounding_saturation();
    test_ignored_items();
    test_writeback();
    test_order_limits();
    test_backpressure();
    test_random(20);
    send_idle_pct = 62;
    recv_idle_pct = 36;
    test_random(20);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(20);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ptm_pkg.sv
hw/rtl/ptm_ram.sv
hw/rtl/ptm_front.sv
hw/rtl/ptm_result_queue.sv
hw/rtl/ptm_back.sv
hw/rtl/packed_triangular_matvec_top.sv
tb/sv/tb.sv
